// ===== rtl/pas_pkg.sv =====
package pas_pkg;

  localparam int COORD_W      = 16;
  localparam int PROD_W       = 2 * COORD_W;
  localparam int TERM_W       = PROD_W + 1;
  localparam int CROSS_W      = 48;
  localparam int AREA_W       = 47;
  localparam int VCNT_W       = 11;
  localparam int SUM_W        = 64;
  localparam int CNT_W        = 32;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;
  localparam int MAX_VERTICES = 1024;

  localparam logic [VCNT_W-1:0] VCNT_MAX    = VCNT_W'(MAX_VERTICES);
  localparam logic [VCNT_W-1:0] TARGET_RST  = VCNT_W'(3);

  typedef enum logic [1:0] {
    FILTER_ALL   = 2'd0,
    FILTER_EVEN  = 2'd1,
    FILTER_ODD   = 2'd2,
    FILTER_EXACT = 2'd3
  } filter_e;

  typedef enum logic {
    REG_FILTER = 1'b0,
    REG_TARGET = 1'b1
  } reg_e;

  typedef struct packed {
    filter_e             mode;
    logic [VCNT_W-1:0]   target;
  } cfg_t;

  // per vertex cross terms
  typedef struct packed {
    logic signed [TERM_W-1:0] edge_term;
    logic signed [TERM_W-1:0] close_term;
    logic                     closing;
    logic                     clr;
    logic [VCNT_W-1:0]        n;
  } term_t;

  // one closed polygon
  typedef struct packed {
    logic [AREA_W-1:0] mag;
    logic [VCNT_W-1:0] n;
    logic              match;
    logic              clr;
  } poly_t;

endpackage

// ===== rtl/pas_cfg.sv =====
module pas_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pas_pkg::ADDR_W-1:0]  paddr,
  input  logic [pas_pkg::DATA_W-1:0]  pwdata,
  output logic [pas_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output pas_pkg::cfg_t               cfg_o
);

  pas_pkg::cfg_t cfg_q, cfg_d;
  pas_pkg::reg_e sel;
  logic          wr;

  assign sel    = pas_pkg::reg_e'(paddr[2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (sel)
        pas_pkg::REG_FILTER: cfg_d.mode   = pas_pkg::filter_e'(pwdata[1:0]);
        pas_pkg::REG_TARGET: cfg_d.target = pwdata[pas_pkg::VCNT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      pas_pkg::REG_FILTER: prdata = pas_pkg::DATA_W'(cfg_q.mode);
      pas_pkg::REG_TARGET: prdata = pas_pkg::DATA_W'(cfg_q.target);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= pas_pkg::FILTER_ALL;
      cfg_q.target <= pas_pkg::TARGET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/pas_edge.sv =====
module pas_edge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [pas_pkg::COORD_W-1:0] x_coord_i,
  input  logic signed [pas_pkg::COORD_W-1:0] y_coord_i,
  input  logic                               last_vertex_i,
  input  logic                               new_set_i,
  output logic                               term_valid_o,
  output pas_pkg::term_t                     term_o,
  input  logic                               term_ready_i
);

  logic                               in_poly_q, in_poly_d;
  logic [pas_pkg::VCNT_W-1:0]         cnt_q, cnt_d, cnt_next;
  logic signed [pas_pkg::COORD_W-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic signed [pas_pkg::COORD_W-1:0] prev_x_q, prev_y_q;
  logic                               clr_q, clr_d;
  logic                               v_q, v_d;
  pas_pkg::term_t                     term_q, term_d;
  logic                               start, accept, ready;
  logic signed [pas_pkg::PROD_W-1:0]  pe1, pe2, pc1, pc2;

  assign ready      = !v_q || term_ready_i;
  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;
  assign start      = !in_poly_q;

  always_comb begin
    cnt_next  = start ? pas_pkg::VCNT_W'(1) : cnt_q + pas_pkg::VCNT_W'(1);
    first_x_d = start ? x_coord_i : first_x_q;
    first_y_d = start ? y_coord_i : first_y_q;
    clr_d     = start ? new_set_i : clr_q;

    // shoelace terms: previous-to-this and this-to-first
    pe1 = prev_x_q * y_coord_i;
    pe2 = x_coord_i * prev_y_q;
    pc1 = x_coord_i * first_y_d;
    pc2 = first_x_d * y_coord_i;

    term_d.edge_term  = start ? '0 : ({pe1[pas_pkg::PROD_W-1], pe1} -
                                      {pe2[pas_pkg::PROD_W-1], pe2});
    term_d.close_term = {pc1[pas_pkg::PROD_W-1], pc1} - {pc2[pas_pkg::PROD_W-1], pc2};
    term_d.closing    = last_vertex_i || (cnt_next >= pas_pkg::VCNT_MAX);
    term_d.clr        = clr_d;
    term_d.n          = cnt_next;

    in_poly_d = accept ? !term_d.closing : in_poly_q;
    cnt_d     = accept ? (term_d.closing ? '0 : cnt_next) : cnt_q;
    v_d       = accept ? 1'b1 : (term_ready_i ? 1'b0 : v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_poly_q <= 1'b0;
      cnt_q     <= '0;
      v_q       <= 1'b0;
      clr_q     <= 1'b0;
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
    end else begin
      in_poly_q <= in_poly_d;
      cnt_q     <= cnt_d;
      v_q       <= v_d;
      if (accept) begin
        clr_q     <= clr_d;
        first_x_q <= first_x_d;
        first_y_q <= first_y_d;
        prev_x_q  <= x_coord_i;
        prev_y_q  <= y_coord_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      term_q <= term_d;
    end
  end

  assign term_valid_o = v_q;
  assign term_o       = term_q;

endmodule

// ===== rtl/pas_accum.sv =====
module pas_accum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pas_pkg::cfg_t  cfg_i,
  input  logic           term_valid_i,
  input  pas_pkg::term_t term_i,
  output logic           term_ready_o,
  output logic           poly_valid_o,
  output pas_pkg::poly_t poly_o,
  input  logic           poly_ready_i
);

  logic [pas_pkg::CROSS_W-1:0] cross_q, cross_d, acc, total, neg, mag_raw;
  logic                        v_q, v_d, take, match;
  pas_pkg::poly_t              poly_q, poly_d;

  assign term_ready_o = !v_q || poly_ready_i;
  assign take         = term_valid_i && term_ready_o;

  always_comb begin
    acc   = cross_q + pas_pkg::CROSS_W'(term_i.edge_term);
    total = acc + pas_pkg::CROSS_W'(term_i.close_term);
    neg   = '0 - total;
    mag_raw = total[pas_pkg::CROSS_W-1] ? neg : total;

    case (cfg_i.mode)
      pas_pkg::FILTER_ALL:   match = 1'b1;
      pas_pkg::FILTER_EVEN:  match = !term_i.n[0];
      pas_pkg::FILTER_ODD:   match = term_i.n[0];
      pas_pkg::FILTER_EXACT: match = (term_i.n == cfg_i.target);
      default:               match = 1'b0;
    endcase

    // magnitude of 2^47 saturates
    poly_d.mag   = mag_raw[pas_pkg::CROSS_W-1] ? '1 : mag_raw[pas_pkg::AREA_W-1:0];
    poly_d.n     = term_i.n;
    poly_d.match = match;
    poly_d.clr   = term_i.clr;

    cross_d = take ? (term_i.closing ? '0 : acc) : cross_q;
    v_d     = take ? term_i.closing : (poly_ready_i ? 1'b0 : v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cross_q <= '0;
      v_q     <= 1'b0;
    end else begin
      cross_q <= cross_d;
      v_q     <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && term_i.closing) begin
      poly_q <= poly_d;
    end
  end

  assign poly_valid_o = v_q;
  assign poly_o       = poly_q;

endmodule

// ===== rtl/pas_stats.sv =====
module pas_stats (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        poly_valid_i,
  input  pas_pkg::poly_t              poly_i,
  output logic                        poly_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pas_pkg::AREA_W-1:0]  twice_area_o,
  output logic [pas_pkg::VCNT_W-1:0]  vertex_total_o,
  output logic                        matched_o,
  output logic [pas_pkg::SUM_W-1:0]   sum_twice_area_o,
  output logic [pas_pkg::CNT_W-1:0]   match_count_o,
  output logic [pas_pkg::CNT_W-1:0]   polygon_count_o,
  output logic [pas_pkg::AREA_W-1:0]  max_twice_area_o,
  output logic [pas_pkg::AREA_W-1:0]  min_twice_area_o,
  output logic [pas_pkg::VCNT_W-1:0]  max_vertex_total_o,
  output logic [pas_pkg::VCNT_W-1:0]  min_vertex_total_o
);

  logic                       ov_q, ov_d, load;
  logic [pas_pkg::AREA_W-1:0] area_q, area_d;
  logic [pas_pkg::VCNT_W-1:0] n_q, n_d;
  logic                       match_q, match_d;
  logic [pas_pkg::SUM_W-1:0]  sum_q, sum_d, sum_b;
  logic [pas_pkg::SUM_W:0]    sum_add;
  logic [pas_pkg::CNT_W-1:0]  mcnt_q, mcnt_d, mcnt_b, pcnt_q, pcnt_d, pcnt_b;
  logic [pas_pkg::AREA_W-1:0] amax_q, amax_d, amax_b, amin_q, amin_d, amin_b;
  logic [pas_pkg::VCNT_W-1:0] vmax_q, vmax_d, vmax_b, vmin_q, vmin_d, vmin_b;

  assign poly_ready_o = !ov_q || !out_stall_i;
  assign load         = poly_valid_i && poly_ready_o;

  always_comb begin
    // new set starts from cleared totals
    sum_b  = poly_i.clr ? '0 : sum_q;
    mcnt_b = poly_i.clr ? '0 : mcnt_q;
    pcnt_b = poly_i.clr ? '0 : pcnt_q;
    amax_b = poly_i.clr ? '0 : amax_q;
    amin_b = poly_i.clr ? '1 : amin_q;
    vmax_b = poly_i.clr ? '0 : vmax_q;
    vmin_b = poly_i.clr ? '1 : vmin_q;

    sum_add = {1'b0, sum_b} + (pas_pkg::SUM_W + 1)'(poly_i.mag);

    area_d  = area_q;
    n_d     = n_q;
    match_d = match_q;
    sum_d   = sum_q;
    mcnt_d  = mcnt_q;
    pcnt_d  = pcnt_q;
    amax_d  = amax_q;
    amin_d  = amin_q;
    vmax_d  = vmax_q;
    vmin_d  = vmin_q;
    if (load) begin
      area_d  = poly_i.mag;
      n_d     = poly_i.n;
      match_d = poly_i.match;
      sum_d   = !poly_i.match ? sum_b :
                (sum_add[pas_pkg::SUM_W] ? '1 : sum_add[pas_pkg::SUM_W-1:0]);
      mcnt_d  = (poly_i.match && (mcnt_b != '1)) ? mcnt_b + pas_pkg::CNT_W'(1) : mcnt_b;
      pcnt_d  = (pcnt_b != '1) ? pcnt_b + pas_pkg::CNT_W'(1) : pcnt_b;
      amax_d  = (poly_i.mag > amax_b) ? poly_i.mag : amax_b;
      amin_d  = (poly_i.mag < amin_b) ? poly_i.mag : amin_b;
      vmax_d  = (poly_i.n > vmax_b) ? poly_i.n : vmax_b;
      vmin_d  = (poly_i.n < vmin_b) ? poly_i.n : vmin_b;
    end

    ov_d = load ? 1'b1 : (out_stall_i ? ov_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      area_q  <= '0;
      n_q     <= '0;
      match_q <= 1'b0;
      sum_q   <= '0;
      mcnt_q  <= '0;
      pcnt_q  <= '0;
      amax_q  <= '0;
      amin_q  <= '1;
      vmax_q  <= '0;
      vmin_q  <= '1;
    end else begin
      ov_q    <= ov_d;
      area_q  <= area_d;
      n_q     <= n_d;
      match_q <= match_d;
      sum_q   <= sum_d;
      mcnt_q  <= mcnt_d;
      pcnt_q  <= pcnt_d;
      amax_q  <= amax_d;
      amin_q  <= amin_d;
      vmax_q  <= vmax_d;
      vmin_q  <= vmin_d;
    end
  end

  assign out_valid_o        = ov_q;
  assign twice_area_o       = area_q;
  assign vertex_total_o     = n_q;
  assign matched_o          = match_q;
  assign sum_twice_area_o   = sum_q;
  assign match_count_o      = mcnt_q;
  assign polygon_count_o    = pcnt_q;
  assign max_twice_area_o   = amax_q;
  assign min_twice_area_o   = amin_q;
  assign max_vertex_total_o = vmax_q;
  assign min_vertex_total_o = vmin_q;

  a_vtx_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (vmin_q <= n_q) && (n_q <= vmax_q))
    else $error("vertex total outside set extremes");

  a_area_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (amin_q <= area_q) && (area_q <= amax_q))
    else $error("twice area outside set extremes");

  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (mcnt_q <= pcnt_q) && (pcnt_q != '0))
    else $error("match count exceeds polygon count");

  a_sum_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && match_q |-> (sum_q >= pas_pkg::SUM_W'(area_q)) && (mcnt_q != '0))
    else $error("matching polygon missing from area sum");

endmodule

// ===== rtl/polygon_area_stats.sv =====
// polygon_area_stats: streaming shoelace area of polygons with set statistics
// input channel: one vertex per word (x, y, last_vertex, new_set); a polygon
// ends on last_vertex or on its 1024th vertex. output channel: one word per
// closed polygon with twice its area, its vertex count, the filter result and
// the running set totals after this polygon. non-closing vertices give no word.
// three register stages: cross products, accumulate and magnitude, statistics
// and output register. a closing vertex passes term_q, poly_q and the output
// registers. one vertex per cycle is sustained when not stalled, set by the
// four 16x16 multiplies of the product stage and the 48-bit accumulate loop.
// each stage takes a new word when it is empty or its word moves on, so input
// keeps flowing into empty stages while the output word is stalled; in_stall_o
// rises only once all stages hold words. reset empties the pipeline, drops any
// open polygon and clears the set totals (minimum fields to all ones);
// filter_mode resets to all polygons and target_vertices to 3. configuration
// must be written over the apb port while idle; the block does not enforce it.
module polygon_area_stats (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [pas_pkg::COORD_W-1:0] x_coord_i,
  input  logic signed [pas_pkg::COORD_W-1:0] y_coord_i,
  input  logic                               last_vertex_i,
  input  logic                               new_set_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pas_pkg::AREA_W-1:0]         twice_area_o,
  output logic [pas_pkg::VCNT_W-1:0]         vertex_total_o,
  output logic                               matched_o,
  output logic [pas_pkg::SUM_W-1:0]          sum_twice_area_o,
  output logic [pas_pkg::CNT_W-1:0]          match_count_o,
  output logic [pas_pkg::CNT_W-1:0]          polygon_count_o,
  output logic [pas_pkg::AREA_W-1:0]         max_twice_area_o,
  output logic [pas_pkg::AREA_W-1:0]         min_twice_area_o,
  output logic [pas_pkg::VCNT_W-1:0]         max_vertex_total_o,
  output logic [pas_pkg::VCNT_W-1:0]         min_vertex_total_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pas_pkg::ADDR_W-1:0]         paddr,
  input  logic [pas_pkg::DATA_W-1:0]         pwdata,
  output logic [pas_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  pas_pkg::cfg_t  cfg;
  pas_pkg::term_t term;
  pas_pkg::poly_t poly;
  logic           term_valid, term_ready, poly_valid, poly_ready;

  pas_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pas_edge u_edge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .last_vertex_i (last_vertex_i),
    .new_set_i     (new_set_i),
    .term_valid_o  (term_valid),
    .term_o        (term),
    .term_ready_i  (term_ready)
  );

  pas_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .term_valid_i (term_valid),
    .term_i       (term),
    .term_ready_o (term_ready),
    .poly_valid_o (poly_valid),
    .poly_o       (poly),
    .poly_ready_i (poly_ready)
  );

  pas_stats u_stats (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .poly_valid_i       (poly_valid),
    .poly_i             (poly),
    .poly_ready_o       (poly_ready),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .twice_area_o       (twice_area_o),
    .vertex_total_o     (vertex_total_o),
    .matched_o          (matched_o),
    .sum_twice_area_o   (sum_twice_area_o),
    .match_count_o      (match_count_o),
    .polygon_count_o    (polygon_count_o),
    .max_twice_area_o   (max_twice_area_o),
    .min_twice_area_o   (min_twice_area_o),
    .max_vertex_total_o (max_vertex_total_o),
    .min_vertex_total_o (min_vertex_total_o)
  );

endmodule

// ===== dv/polygon_area_stats_test.sv =====
module polygon_area_stats_test;

  localparam int COORD_W      = pas_pkg::COORD_W;
  localparam int CROSS_W      = pas_pkg::CROSS_W;
  localparam int AREA_W       = pas_pkg::AREA_W;
  localparam int VCNT_W       = pas_pkg::VCNT_W;
  localparam int SUM_W        = pas_pkg::SUM_W;
  localparam int CNT_W        = pas_pkg::CNT_W;
  localparam int ADDR_W       = pas_pkg::ADDR_W;
  localparam int DATA_W       = pas_pkg::DATA_W;
  localparam int MAX_VERTICES = pas_pkg::MAX_VERTICES;

  localparam logic [VCNT_W-1:0] VCNT_MAX   = pas_pkg::VCNT_MAX;
  localparam logic [VCNT_W-1:0] TARGET_RST = pas_pkg::TARGET_RST;

  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int END_WAIT         = 800;
  localparam int PIPE_DRAIN       = 4;
  localparam int RANDOM_VERTICES  = 60;
  localparam int MAX_REPORTS      = 200;

  localparam logic [CROSS_W-1:0] AREA_SAT = {1'b0, {AREA_W{1'b1}}};

  typedef enum int {
    COORD_SMALL,
    COORD_FULL,
    COORD_EDGE,
    COORD_MIXED
  } coord_kind_e;

  typedef struct {
    logic [AREA_W-1:0] area;
    logic [VCNT_W-1:0] n;
    logic              hit;
    logic [SUM_W-1:0]  area_sum;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  polys;
    logic [AREA_W-1:0] max_area;
    logic [AREA_W-1:0] min_area;
    logic [VCNT_W-1:0] max_n;
    logic [VCNT_W-1:0] min_n;
  } poly_stats_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [COORD_W-1:0] x_coord_i = '0;
  logic signed [COORD_W-1:0] y_coord_i = '0;
  logic                      last_vertex_i = 1'b0;
  logic                      new_set_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [AREA_W-1:0]         twice_area_o;
  logic [VCNT_W-1:0]         vertex_total_o;
  logic                      matched_o;
  logic [SUM_W-1:0]          sum_twice_area_o;
  logic [CNT_W-1:0]          match_count_o;
  logic [CNT_W-1:0]          polygon_count_o;
  logic [AREA_W-1:0]         max_twice_area_o;
  logic [AREA_W-1:0]         min_twice_area_o;
  logic [VCNT_W-1:0]         max_vertex_total_o;
  logic [VCNT_W-1:0]         min_vertex_total_o;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  polygon_area_stats dut (.*);

  always #4 clk_i = ~clk_i;

  // shadow of the block's state
  pas_pkg::filter_e          cfg_mode = pas_pkg::FILTER_ALL;
  logic [VCNT_W-1:0]         cfg_target = TARGET_RST;
  bit                        poly_open = 1'b0;
  logic signed [COORD_W-1:0] first_x = '0, first_y = '0, prev_x = '0, prev_y = '0;
  logic [VCNT_W-1:0]         vcount = '0;
  logic [CROSS_W-1:0]        cross_acc = '0;
  logic [SUM_W-1:0]          set_area_sum = '0;
  logic [CNT_W-1:0]          set_hits = '0;
  logic [CNT_W-1:0]          set_polys = '0;
  logic [AREA_W-1:0]         set_max_area = '0;
  logic [AREA_W-1:0]         set_min_area = '1;
  logic [VCNT_W-1:0]         set_max_n = '0;
  logic [VCNT_W-1:0]         set_min_n = '1;

  poly_stats_t expected_polys[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  bit          idling_on = 1'b1;
  logic [15:0] stall_cycle = '0;

  function automatic logic [CROSS_W-1:0] cross_product(
    input logic signed [COORD_W-1:0] ax, ay, bx, by
  );
    longint t;
    t = longint'(ax) * longint'(by) - longint'(bx) * longint'(ay);
    return t[CROSS_W-1:0];
  endfunction

  function automatic void clear_set_totals();
    set_area_sum = '0;
    set_hits     = '0;
    set_polys    = '0;
    set_max_area = '0;
    set_min_area = '1;
    set_max_n    = '0;
    set_min_n    = '1;
  endfunction

  function automatic void predict_vertex(
    input logic signed [COORD_W-1:0] x, y,
    input bit is_last, fresh
  );
    logic [CROSS_W-1:0] closed_sum, mag;
    logic [SUM_W:0]     wide_sum;
    poly_stats_t        r;
    if (!poly_open) begin
      if (fresh) clear_set_totals();
      first_x   = x;
      first_y   = y;
      cross_acc = '0;
      vcount    = VCNT_W'(1);
      poly_open = 1'b1;
    end else begin
      cross_acc = cross_acc + cross_product(prev_x, prev_y, x, y);
      vcount    = vcount + VCNT_W'(1);
    end
    prev_x = x;
    prev_y = y;
    if (!is_last && vcount < VCNT_MAX) return;

    // close with the last-to-first term
    closed_sum = cross_acc + cross_product(x, y, first_x, first_y);
    mag = closed_sum[CROSS_W-1] ? (~closed_sum + CROSS_W'(1)) : closed_sum;
    if (mag > AREA_SAT) mag = AREA_SAT;
    r.area    = mag[AREA_W-1:0];
    r.n       = vcount;
    poly_open = 1'b0;
    vcount    = '0;
    cross_acc = '0;

    case (cfg_mode)
      pas_pkg::FILTER_ALL:  r.hit = 1'b1;
      pas_pkg::FILTER_EVEN: r.hit = !r.n[0];
      pas_pkg::FILTER_ODD:  r.hit = r.n[0];
      default:              r.hit = (r.n == cfg_target);
    endcase

    if (r.hit) begin
      wide_sum = {1'b0, set_area_sum} + (SUM_W+1)'(r.area);
      set_area_sum = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
      if (set_hits != '1) set_hits = set_hits + CNT_W'(1);
    end
    if (set_polys != '1) set_polys = set_polys + CNT_W'(1);
    if (r.area > set_max_area) set_max_area = r.area;
    if (r.area < set_min_area) set_min_area = r.area;
    if (r.n > set_max_n) set_max_n = r.n;
    if (r.n < set_min_n) set_min_n = r.n;

    r.area_sum = set_area_sum;
    r.hits     = set_hits;
    r.polys    = set_polys;
    r.max_area = set_max_area;
    r.min_area = set_min_area;
    r.max_n    = set_max_n;
    r.min_n    = set_min_n;
    expected_polys.push_back(r);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got, want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // result words
  always @(posedge clk_i) begin : result_check
    poly_stats_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_polys.size() == 0) begin
        report_mismatch("polygon word with nothing expected");
      end else begin
        want = expected_polys.pop_front();
        check_field("twice_area", 64'(twice_area_o), 64'(want.area));
        check_field("vertex_total", 64'(vertex_total_o), 64'(want.n));
        check_field("matched", 64'(matched_o), 64'(want.hit));
        check_field("sum_twice_area", sum_twice_area_o, want.area_sum);
        check_field("match_count", 64'(match_count_o), 64'(want.hits));
        check_field("polygon_count", 64'(polygon_count_o), 64'(want.polys));
        check_field("max_twice_area", 64'(max_twice_area_o), 64'(want.max_area));
        check_field("min_twice_area", 64'(min_twice_area_o), 64'(want.min_area));
        check_field("max_vertex_total", 64'(max_vertex_total_o), 64'(want.max_n));
        check_field("min_vertex_total", 64'(min_vertex_total_o), 64'(want.min_n));
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 16'd1;
    case (stall_cycle[9:8])
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 9) < 3);
      2'd2:    out_stall_i <= ($urandom_range(0, 9) < 7);
      default: out_stall_i <= (stall_cycle[3:0] < 4'd10);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_vertex(
    input logic signed [COORD_W-1:0] x, y,
    input bit is_last, fresh
  );
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if (idling_on)
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    x_coord_i     <= x;
    y_coord_i     <= y;
    last_vertex_i <= is_last;
    new_set_i     <= fresh;
    do @(posedge clk_i); while (in_stall_o);
    predict_vertex(x, y, is_last, fresh);
  endtask

  task automatic pause_sender();
    in_valid_i <= 1'b0;
    while (expected_polys.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(input pas_pkg::reg_e idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == pas_pkg::REG_FILTER) cfg_mode = pas_pkg::filter_e'(value[1:0]);
    else cfg_target = value[VCNT_W-1:0];
  endtask

  task automatic set_filter(input pas_pkg::filter_e mode, input logic [VCNT_W-1:0] target);
    pause_sender();
    write_reg(pas_pkg::REG_FILTER, DATA_W'(mode));
    write_reg(pas_pkg::REG_TARGET, DATA_W'(target));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord(input coord_kind_e kind);
    coord_kind_e k;
    k = (kind == COORD_MIXED) ? coord_kind_e'($urandom_range(0, 2)) : kind;
    case (k)
      COORD_SMALL: return COORD_W'(int'($urandom_range(0, 400)) - 200);
      COORD_FULL:  return COORD_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  // late new_set sprinkled on inner vertices, where it must be ignored
  task automatic send_polygon(
    input int count, input bit fresh, input bit mark_last, input coord_kind_e kind
  );
    int i;
    bit late;
    for (i = 0; i < count; i++) begin
      late = (i > 0) && ($urandom_range(0, 9) == 0);
      send_vertex(rand_coord(kind), rand_coord(kind), mark_last && (i == count - 1),
                  (i == 0) ? fresh : late);
    end
  endtask

  task automatic test_directed_shapes();
    idling_on = 1'b0;
    // counterclockwise and clockwise triangles
    send_vertex(16'sd0, 16'sd0, 1'b0, 1'b1);
    send_vertex(16'sd4, 16'sd0, 1'b0, 1'b0);
    send_vertex(16'sd0, 16'sd3, 1'b1, 1'b0);
    send_vertex(16'sd0, 16'sd0, 1'b0, 1'b0);
    send_vertex(16'sd0, 16'sd3, 1'b0, 1'b0);
    send_vertex(16'sd4, 16'sd0, 1'b1, 1'b0);
    // short polygons
    send_vertex(16'sd7, 16'sd7, 1'b1, 1'b0);
    send_vertex(16'sh8000, 16'sh8000, 1'b0, 1'b0);
    send_vertex(16'sh7fff, 16'sh7fff, 1'b1, 1'b0);
    // full range square, late new_set inside
    send_vertex(16'sh8000, 16'sh8000, 1'b0, 1'b0);
    send_vertex(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
    send_vertex(16'sh7fff, 16'sh7fff, 1'b0, 1'b1);
    send_vertex(16'sh8000, 16'sh7fff, 1'b1, 1'b0);
    // new set clears the totals
    send_vertex(-16'sd1, -16'sd1, 1'b0, 1'b1);
    send_vertex(16'sd5, -16'sd2, 1'b0, 1'b0);
    send_vertex(16'sd2, 16'sd9, 1'b0, 1'b0);
    send_vertex(-16'sd6, 16'sd4, 1'b1, 1'b0);
    pause_sender();
    idling_on = 1'b1;
  endtask

  task automatic test_filter_modes();
    pas_pkg::filter_e modes [8] = '{pas_pkg::FILTER_ALL, pas_pkg::FILTER_EVEN,
                                    pas_pkg::FILTER_ODD, pas_pkg::FILTER_EXACT,
                                    pas_pkg::FILTER_EXACT, pas_pkg::FILTER_EXACT,
                                    pas_pkg::FILTER_EXACT, pas_pkg::FILTER_EXACT};
    int               targets [8] = '{3, 3, 3, 3, 1, 0, 2047, 6};
    int s, sz;
    for (s = 0; s < 8; s++) begin
      set_filter(modes[s], VCNT_W'(targets[s]));
      for (sz = 1; sz <= 6; sz++) send_polygon(sz, sz == 1, 1'b1, COORD_MIXED);
    end
  endtask

  // the limit closes the first polygon, the remaining vertices form a new one
  task automatic test_vertex_limit();
    set_filter(pas_pkg::FILTER_EXACT, VCNT_MAX);
    send_polygon(MAX_VERTICES + 2, 1'b1, 1'b1, COORD_MIXED);
    pause_sender();
  endtask

  task automatic test_random_polygons();
    int                sent, phase_end, count, pick;
    logic [VCNT_W-1:0] target;
    sent = 0;
    while (sent < RANDOM_VERTICES) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) target = VCNT_W'($urandom_range(1, 8));
      else if (pick == 7) target = VCNT_W'($urandom_range(0, 2047));
      else target = VCNT_MAX;
      set_filter(pas_pkg::filter_e'($urandom_range(0, 3)), target);
      idling_on = ($urandom_range(0, 3) != 0);
      phase_end = sent + $urandom_range(20, 40);
      while (sent < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 16) count = $urandom_range(1, 8);
        else if (pick < 19) count = $urandom_range(9, 40);
        else count = $urandom_range(41, 120);
        send_polygon(count, $urandom_range(0, 5) == 0, 1'b1,
                     coord_kind_e'($urandom_range(0, 3)));
        sent += count;
      end
    end
    idling_on = 1'b1;
  endtask

  initial begin
    int wait_cycles;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_shapes();
    test_filter_modes();
    test_vertex_limit();
    test_random_polygons();

    in_valid_i <= 1'b0;
    for (wait_cycles = 0; wait_cycles < END_WAIT && expected_polys.size() != 0;
         wait_cycles++)
      @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
    if (expected_polys.size() != 0)
      report_mismatch($sformatf("%0d polygon words never arrived", expected_polys.size()));
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pas_pkg.sv
rtl/pas_cfg.sv
rtl/pas_edge.sv
rtl/pas_accum.sv
rtl/pas_stats.sv
rtl/polygon_area_stats.sv
dv/polygon_area_stats_test.sv
